// ===== rtl/sqvg_pkg.sv =====
// shared types and constants for the sprite quad vertex generator
package sqvg_pkg;

	localparam int CORDIC_STEPS = 28;
	localparam logic signed [33:0] TRIG_ONE = 34'sd1073741824;
	localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

	// register indexes
	localparam logic [2:0] REG_START_COLOR = 3'd0;
	localparam logic [2:0] REG_END_COLOR   = 3'd1;
	localparam logic [2:0] REG_START_SCALE = 3'd2;
	localparam logic [2:0] REG_END_SCALE   = 3'd3;
	localparam logic [2:0] REG_LIFE_RECIP  = 3'd4;
	localparam logic [2:0] REG_PREMULT     = 3'd5;

	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		case (i)
			5'd0: atan_turn = 30'd536870912;
			5'd1: atan_turn = 30'd316933406;
			5'd2: atan_turn = 30'd167458907;
			5'd3: atan_turn = 30'd85004756;
			5'd4: atan_turn = 30'd42667331;
			5'd5: atan_turn = 30'd21354465;
			5'd6: atan_turn = 30'd10679838;
			5'd7: atan_turn = 30'd5340245;
			5'd8: atan_turn = 30'd2670163;
			5'd9: atan_turn = 30'd1335087;
			5'd10: atan_turn = 30'd667544;
			5'd11: atan_turn = 30'd333772;
			5'd12: atan_turn = 30'd166886;
			5'd13: atan_turn = 30'd83443;
			5'd14: atan_turn = 30'd41722;
			5'd15: atan_turn = 30'd20861;
			5'd16: atan_turn = 30'd10430;
			5'd17: atan_turn = 30'd5215;
			5'd18: atan_turn = 30'd2608;
			5'd19: atan_turn = 30'd1304;
			5'd20: atan_turn = 30'd652;
			5'd21: atan_turn = 30'd326;
			5'd22: atan_turn = 30'd163;
			5'd23: atan_turn = 30'd81;
			5'd24: atan_turn = 30'd41;
			5'd25: atan_turn = 30'd20;
			5'd26: atan_turn = 30'd10;
			5'd27: atan_turn = 30'd5;
			default: atan_turn = 30'd0;
		endcase
	endfunction

	// one particle worth of payload moving down the cordic chain
	typedef struct packed {
		logic [1:0]         quad;
		logic [23:0]        size_x;
		logic [23:0]        size_y;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic [15:0]        tex_width;
		logic [15:0]        tex_height;
		logic               tex_rotated;
	} sqvg_item_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [31:0] z;
	} sqvg_rot_t;

endpackage

// ===== rtl/sqvg_cell.sv =====
// one cordic rotation cell of the chain, registered
module sqvg_cell #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  sqvg_pkg::sqvg_rot_t  in_rot,
	input  sqvg_pkg::sqvg_item_t in_item,
	output logic                 out_valid,
	output sqvg_pkg::sqvg_rot_t  out_rot,
	output sqvg_pkg::sqvg_item_t out_item
);

	logic signed [33:0] xs, ys;
	logic signed [31:0] at;
	sqvg_pkg::sqvg_rot_t nxt;

	always_comb begin
		xs = in_rot.x >>> STEP;
		ys = in_rot.y >>> STEP;
		at = signed'({2'b00, sqvg_pkg::atan_turn(5'(STEP))});
		if (!in_rot.z[31]) begin
			nxt.x = in_rot.x - ys;
			nxt.y = in_rot.y + xs;
			nxt.z = in_rot.z - at;
		end else begin
			nxt.x = in_rot.x + ys;
			nxt.y = in_rot.y - xs;
			nxt.z = in_rot.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rot  <= nxt;
			out_item <= in_item;
		end
	end

endmodule

// ===== rtl/sqvg_front.sv =====
// tween, color and scale blend, size and phase set-up stages
module sqvg_front #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [15:0]          age,
	input  logic signed [23:0]   pos_x,
	input  logic signed [23:0]   pos_y,
	input  logic [15:0]          angle,
	input  logic [15:0]          sprite_width,
	input  logic [15:0]          sprite_height,
	input  logic [15:0]          tex_u,
	input  logic [15:0]          tex_v,
	input  logic [15:0]          tex_width,
	input  logic [15:0]          tex_height,
	input  logic                 tex_rotated,
	input  logic [31:0]          start_color,
	input  logic [31:0]          end_color,
	input  logic [31:0]          start_scale,
	input  logic [31:0]          end_scale,
	input  logic [16:0]          life_reciprocal,
	input  logic                 premultiply_alpha,
	output logic                 out_valid,
	output sqvg_pkg::sqvg_rot_t  out_rot,
	output sqvg_pkg::sqvg_item_t out_item
);

	// stage 1: tween
	logic        v_s1;
	logic [16:0] t_s1;
	logic [32:0] prod_t;
	logic [15:0] ang_s1, sw_s1, sh_s1;
	logic signed [23:0] px_s1, py_s1;
	logic [15:0] u_s1, vv_s1, w_s1, h_s1;
	logic rot_s1;

	assign prod_t = age * life_reciprocal;

	// stage 2: blends
	logic        v_s2;
	logic [7:0]  col_s2 [4];
	logic [15:0] scx_s2, scy_s2;
	logic [15:0] ang_s2, sw_s2, sh_s2;
	logic signed [23:0] px_s2, py_s2;
	logic [15:0] u_s2, vv_s2, w_s2, h_s2;
	logic rot_s2;

	function automatic logic [15:0] blend(input logic [15:0] s, input logic [15:0] e,
		input logic [16:0] t);
		logic [33:0] acc;
		acc = 34'(s) * 34'(17'h10000 - t) + 34'(e) * 34'(t) + 34'd32768;
		return acc[31:16];
	endfunction

	// stage 3: sizes and premultiply
	logic        v_s3;
	logic [31:0] szx_full, szy_full;
	logic [7:0]  pm [3];
	logic [15:0] pm_prod [3];
	logic [16:0] pm_sum [3];

	assign szx_full = sw_s2 * scx_s2 + 32'd128;
	assign szy_full = sh_s2 * scy_s2 + 32'd128;

	// (n + 127) / 255 for n < 65536: q = (n + (n >> 8) + 1) >> 8 after offset
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pm_prod[k] = col_s2[k] * col_s2[3];
			pm_sum[k] = 17'(pm_prod[k]) + 17'd127;
			pm[k] = 8'((pm_sum[k] + (pm_sum[k] >> 8) + 17'd1) >> 8);
		end
	end

	logic [23:0] ang24;
	logic [ANGLE_BITS-1:0] phase;
	logic [31:0] z32;

	assign ang24 = {ang_s2, 8'h00};
	assign phase = ang24[23 -: ANGLE_BITS];
	assign z32 = {phase, {(32-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= (prod_t > 33'd65536) ? 17'h10000 : prod_t[16:0];
			ang_s1 <= angle;
			sw_s1  <= sprite_width;
			sh_s1  <= sprite_height;
			px_s1  <= pos_x;
			py_s1  <= pos_y;
			u_s1   <= tex_u;
			vv_s1  <= tex_v;
			w_s1   <= tex_width;
			h_s1   <= tex_height;
			rot_s1 <= tex_rotated;

			for (int k = 0; k < 4; k++) begin
				col_s2[k] <= 8'(blend({8'h00, start_color[24-8*k +: 8]},
					{8'h00, end_color[24-8*k +: 8]}, t_s1));
			end
			scx_s2 <= blend(start_scale[31:16], end_scale[31:16], t_s1);
			scy_s2 <= blend(start_scale[15:0], end_scale[15:0], t_s1);
			ang_s2 <= ang_s1;
			sw_s2  <= sw_s1;
			sh_s2  <= sh_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			u_s2   <= u_s1;
			vv_s2  <= vv_s1;
			w_s2   <= w_s1;
			h_s2   <= h_s1;
			rot_s2 <= rot_s1;

			out_rot.x <= sqvg_pkg::CORDIC_GAIN_INV;
			out_rot.y <= '0;
			out_rot.z <= {2'b00, z32[29:0]};
			out_item.quad <= z32[31:30];
			out_item.size_x <= szx_full[31:8];
			out_item.size_y <= szy_full[31:8];
			out_item.pos_x <= px_s2;
			out_item.pos_y <= py_s2;
			out_item.red   <= premultiply_alpha ? pm[0] : col_s2[0];
			out_item.green <= premultiply_alpha ? pm[1] : col_s2[1];
			out_item.blue  <= premultiply_alpha ? pm[2] : col_s2[2];
			out_item.alpha <= col_s2[3];
			out_item.tex_u <= u_s2;
			out_item.tex_v <= vv_s2;
			out_item.tex_width <= w_s2;
			out_item.tex_height <= h_s2;
			out_item.tex_rotated <= rot_s2;
		end
	end

	assign out_valid = v_s3;

endmodule

// ===== rtl/sqvg_emit.sv =====
// per-quad vertex sequencer: four corner products, saturation and uv rule
module sqvg_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sqvg_pkg::sqvg_rot_t  in_rot,
	input  sqvg_pkg::sqvg_item_t in_item,
	output logic                 valid,
	input  logic                 ready,
	output logic [1:0]           corner,
	output logic signed [23:0]   vert_x,
	output logic signed [23:0]   vert_y,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic [7:0]           alpha,
	output logic [15:0]          out_u,
	output logic [15:0]          out_v,
	output logic                 last_vertex
);

	// held item, trig values resolved for the quadrant
	logic                 busy_q;
	logic [1:0]           k_q;
	sqvg_pkg::sqvg_item_t it_q;
	logic signed [31:0]   c_q, s_q;

	logic signed [33:0] cx, cy;
	logic signed [31:0] c_n, s_n;

	function automatic logic signed [31:0] clampt(input logic signed [33:0] v);
		if (v > sqvg_pkg::TRIG_ONE) return 32'sd1073741824;
		if (v < -sqvg_pkg::TRIG_ONE) return -32'sd1073741824;
		return 32'(v);
	endfunction

	always_comb begin
		cx = in_rot.x;
		cy = in_rot.y;
		case (in_item.quad)
			2'd0: begin c_n = clampt(cx); s_n = clampt(cy); end
			2'd1: begin c_n = -clampt(cy); s_n = clampt(cx); end
			2'd2: begin c_n = -clampt(cx); s_n = -clampt(cy); end
			default: begin c_n = clampt(cy); s_n = -clampt(cx); end
		endcase
	end

	// corner trig
	logic signed [31:0] tx, ty;
	always_comb begin
		case (k_q)
			2'd0: begin tx = c_q; ty = s_q; end
			2'd1: begin tx = -s_q; ty = c_q; end
			2'd2: begin tx = s_q; ty = -c_q; end
			default: begin tx = -c_q; ty = -s_q; end
		endcase
	end

	logic signed [56:0] px, py;
	logic signed [57:0] rx, ry;
	logic signed [26:0] ax, ay;
	assign px = tx * signed'({1'b0, it_q.size_x});
	assign py = ty * signed'({1'b0, it_q.size_y});
	assign rx = 58'(px) + 58'sd536870912;
	assign ry = 58'(py) + 58'sd536870912;
	assign ax = 27'(rx >>> 30) + 27'(it_q.pos_x);
	assign ay = 27'(ry >>> 30) + 27'(it_q.pos_y);

	function automatic logic [23:0] sat24(input logic signed [26:0] v);
		if (v > 27'sd8388607) return 24'h7FFFFF;
		if (v < -27'sd8388608) return 24'h800000;
		return v[23:0];
	endfunction

	logic [16:0] uw, uh, vw, vh;
	logic [15:0] su, sv;
	assign uw = it_q.tex_u + it_q.tex_width;
	assign uh = it_q.tex_u + it_q.tex_height;
	assign vw = it_q.tex_v + it_q.tex_width;
	assign vh = it_q.tex_v + it_q.tex_height;

	always_comb begin
		logic [15:0] suw, suh, svw, svh;
		suw = uw[16] ? 16'hFFFF : uw[15:0];
		suh = uh[16] ? 16'hFFFF : uh[15:0];
		svw = vw[16] ? 16'hFFFF : vw[15:0];
		svh = vh[16] ? 16'hFFFF : vh[15:0];
		if (!it_q.tex_rotated) begin
			su = k_q[0] ? suw : it_q.tex_u;
			sv = k_q[1] ? svh : it_q.tex_v;
		end else begin
			su = (k_q inside {2'd1, 2'd2}) ? suh : it_q.tex_u;
			sv = k_q[1] ? svw : it_q.tex_v;
		end
	end

	logic out_free, step;
	assign out_free = !valid || ready;
	assign step = busy_q && out_free;
	assign in_ready = !busy_q || (step && k_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			valid  <= 1'b0;
		end else begin
			if (out_free) valid <= busy_q;
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (step) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			it_q <= in_item;
			c_q  <= c_n;
			s_q  <= s_n;
		end
		if (step) begin
			corner      <= k_q;
			vert_x      <= sat24(ax);
			vert_y      <= sat24(ay);
			red         <= it_q.red;
			green       <= it_q.green;
			blue        <= it_q.blue;
			alpha       <= it_q.alpha;
			out_u       <= su;
			out_v       <= sv;
			last_vertex <= (k_q == 2'd3);
		end
	end

`ifndef SYNTH
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last_vertex == (corner == 2'd3))) else $error("last flag off");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !ready) |=> (valid && $stable(corner))) else $error("vertex lost");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> busy_q && k_q == 2'd0) else $error("item not held");
`endif

endmodule

// ===== rtl/sprite_quad_vertex_generator_top.sv =====
// top level: register file, front stages, cordic cell chain, vertex sequencer
//
// usage: one particle per transfer on the in_ channel (in_valid/in_ready),
// four vertex transfers per particle on the vertex channel (valid/ready),
// corners 0..3 in order, last_vertex marks corner 3.
// path: 3 front stages, 28 cordic cells, then the vertex sequencer's item
// register and the output register lie between the input transfer and valid
// for the first vertex.
// throughput: the single output port sends four vertices per particle; the
// cell chain itself takes one particle per cycle unless frozen.
// the chain advances as a whole; when the last cell holds a particle the
// sequencer cannot take, the whole chain freezes, so in_ready falls.
// receiver stall: the output register holds its vertex until taken; the
// sequencer and chain wait behind it, nothing is dropped.
// reset: registers take their documented defaults, all pipeline valids clear.
// configuration is written through cfg_we/cfg_index/cfg_data while idle.
module sprite_quad_vertex_generator_top #(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        age,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic [15:0]        angle,
	input  logic [15:0]        sprite_width,
	input  logic [15:0]        sprite_height,
	input  logic [15:0]        tex_u,
	input  logic [15:0]        tex_v,
	input  logic [15:0]        tex_width,
	input  logic [15:0]        tex_height,
	input  logic               tex_rotated,
	output logic               valid,
	input  logic               ready,
	output logic [1:0]         corner,
	output logic signed [23:0] vert_x,
	output logic signed [23:0] vert_y,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         alpha,
	output logic [15:0]        out_u,
	output logic [15:0]        out_v,
	output logic               last_vertex
);

	// configuration registers
	logic [31:0] start_color_q, end_color_q, start_scale_q, end_scale_q;
	logic [16:0] life_recip_q;
	logic        premult_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q <= 32'hFFFFFFFF;
			end_color_q   <= 32'hFFFFFFFF;
			start_scale_q <= 32'h10001000;
			end_scale_q   <= 32'h10001000;
			life_recip_q  <= 17'h10000;
			premult_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				sqvg_pkg::REG_START_COLOR: start_color_q <= cfg_data;
				sqvg_pkg::REG_END_COLOR:   end_color_q <= cfg_data;
				sqvg_pkg::REG_START_SCALE: start_scale_q <= cfg_data;
				sqvg_pkg::REG_END_SCALE:   end_scale_q <= cfg_data;
				sqvg_pkg::REG_LIFE_RECIP:  life_recip_q <= cfg_data[16:0];
				sqvg_pkg::REG_PREMULT:     premult_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// chain enable: everything moves unless the tail holds an item the
	// sequencer cannot take
	logic en, seq_ready;
	logic chain_v [sqvg_pkg::CORDIC_STEPS+1];
	sqvg_pkg::sqvg_rot_t  chain_r [sqvg_pkg::CORDIC_STEPS+1];
	sqvg_pkg::sqvg_item_t chain_i [sqvg_pkg::CORDIC_STEPS+1];

	assign en = !chain_v[sqvg_pkg::CORDIC_STEPS] || seq_ready;
	assign in_ready = en;

	sqvg_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk, .arst_n, .en,
		.in_valid(in_valid),
		.age, .pos_x, .pos_y, .angle, .sprite_width, .sprite_height,
		.tex_u, .tex_v, .tex_width, .tex_height, .tex_rotated,
		.start_color(start_color_q), .end_color(end_color_q),
		.start_scale(start_scale_q), .end_scale(end_scale_q),
		.life_reciprocal(life_recip_q), .premultiply_alpha(premult_q),
		.out_valid(chain_v[0]), .out_rot(chain_r[0]), .out_item(chain_i[0])
	);

	// row of rotation cells, one per cordic step
	for (genvar g = 0; g < sqvg_pkg::CORDIC_STEPS; g++) begin : g_cell
		sqvg_cell #(.STEP(g)) u_cell (
			.clk, .arst_n, .en,
			.in_valid(chain_v[g]), .in_rot(chain_r[g]), .in_item(chain_i[g]),
			.out_valid(chain_v[g+1]), .out_rot(chain_r[g+1]), .out_item(chain_i[g+1])
		);
	end

	sqvg_emit u_emit (
		.clk, .arst_n,
		.in_valid(chain_v[sqvg_pkg::CORDIC_STEPS]),
		.in_ready(seq_ready),
		.in_rot(chain_r[sqvg_pkg::CORDIC_STEPS]),
		.in_item(chain_i[sqvg_pkg::CORDIC_STEPS]),
		.valid, .ready, .corner, .vert_x, .vert_y,
		.red, .green, .blue, .alpha, .out_u, .out_v, .last_vertex
	);

`ifndef SYNTH
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_v[sqvg_pkg::CORDIC_STEPS] && !seq_ready) |-> !in_ready)
		else $error("chain moved while tail blocked");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain_v[sqvg_pkg::CORDIC_STEPS]))
		else $error("tail changed while frozen");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == sqvg_pkg::REG_PREMULT) |=> premult_q == $past(cfg_data[0]))
		else $error("premultiply write lost");
`endif

endmodule

// ===== dv/tb_top.sv =====
// testbench for the sprite quad vertex generator: random particles, quad prediction, vertex check
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		logic [15:0]        age;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [15:0]        angle;
		logic [15:0]        sprite_width;
		logic [15:0]        sprite_height;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic [15:0]        tex_width;
		logic [15:0]        tex_height;
		logic               tex_rotated;
		bit                 drain_first;  // sender waits for all vertices before offering this one
	} particle_t;

	typedef struct {
		logic [1:0]         corner;
		logic signed [23:0] vert_x;
		logic signed [23:0] vert_y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
		logic [15:0]        out_u;
		logic [15:0]        out_v;
		logic               last_vertex;
	} vertex_t;

	localparam int WATCHDOG_LIMIT = 5000;

	// rotation angle per cordic step, Q0.32 turn units
	localparam longint ROT_STEP [28] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid, in_ready;
	logic [15:0] age, angle, sprite_width, sprite_height, tex_u, tex_v, tex_width, tex_height;
	logic signed [23:0] pos_x, pos_y;
	logic tex_rotated;
	logic valid, ready;
	logic [1:0] corner;
	logic signed [23:0] vert_x, vert_y;
	logic [7:0] red, green, blue, alpha;
	logic [15:0] out_u, out_v;
	logic last_vertex;

	// shadow copy of the register file
	logic [31:0] sh_start_color = 32'hFFFF_FFFF;
	logic [31:0] sh_end_color   = 32'hFFFF_FFFF;
	logic [31:0] sh_start_scale = 32'h1000_1000;
	logic [31:0] sh_end_scale   = 32'h1000_1000;
	logic [16:0] sh_life_recip  = 17'd65536;
	logic        sh_premult     = 1'b0;

	particle_t pending_q[$];
	vertex_t   vertex_q[$];

	int particles_sent = 0;
	int vertices_seen = 0;
	int mismatches = 0;
	bit idle_en = 1'b1;
	bit long_hold_done = 1'b0;

	sprite_quad_vertex_generator_top i_dut (.*);

	always #5 clk = ~clk;

	// rounded product of a trig value and a size, plus centre, saturated to 24 bits
	function automatic logic signed [23:0] place(longint tr, longint size, longint pos);
		longint v;
		v = ((tr * size + 64'sd536870912) >>> 30) + pos;
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	function automatic longint mix(longint s, longint e, longint t);
		return (s * (65536 - t) + e * t + 32768) >>> 16;
	endfunction

	function automatic logic [15:0] clip16(longint v);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	// four expected vertices for one accepted particle
	task automatic predict_quad(input particle_t p);
		longint t, x, y, z, xs, ys, c, s, szx, szy, scx, scy;
		longint col[4], cx[4], sy[4], uu[4], vv[4];
		longint u, v, w, h;
		vertex_t vx;
		t = longint'(p.age) * longint'(sh_life_recip);
		if (t > 65536) t = 65536;
		for (int k = 0; k < 4; k++)
			col[k] = mix((sh_start_color >> (24 - 8 * k)) & 8'hFF,
				(sh_end_color >> (24 - 8 * k)) & 8'hFF, t);
		if (sh_premult)
			for (int k = 0; k < 3; k++) col[k] = (col[k] * col[3] + 127) / 255;
		scx = mix(sh_start_scale[31:16], sh_end_scale[31:16], t);
		scy = mix(sh_start_scale[15:0], sh_end_scale[15:0], t);
		szx = (longint'(p.sprite_width) * scx + 128) >>> 8;
		szy = (longint'(p.sprite_height) * scy + 128) >>> 8;
		// quadrant from the top two angle bits, remainder rotated by cordic
		x = 652032874;
		y = 0;
		z = (longint'(p.angle) << 16) & 64'h3FFF_FFFF;
		for (int i = 0; i < 28; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - ROT_STEP[i];
			end else begin
				x = x + ys; y = y - xs; z = z + ROT_STEP[i];
			end
		end
		if (x > 1073741824) x = 1073741824;
		if (x < -1073741824) x = -1073741824;
		if (y > 1073741824) y = 1073741824;
		if (y < -1073741824) y = -1073741824;
		case (p.angle[15:14])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		cx[0] = c;  sy[0] = s;
		cx[1] = -s; sy[1] = c;
		cx[2] = s;  sy[2] = -c;
		cx[3] = -c; sy[3] = -s;
		u = p.tex_u; v = p.tex_v; w = p.tex_width; h = p.tex_height;
		if (!p.tex_rotated) begin
			uu[0] = u;     vv[0] = v;
			uu[1] = u + w; vv[1] = v;
			uu[2] = u;     vv[2] = v + h;
			uu[3] = u + w; vv[3] = v + h;
		end else begin
			uu[0] = u;     vv[0] = v;
			uu[1] = u + h; vv[1] = v;
			uu[2] = u + h; vv[2] = v + w;
			uu[3] = u;     vv[3] = v + w;
		end
		for (int k = 0; k < 4; k++) begin
			vx.corner = k[1:0];
			vx.vert_x = place(cx[k], szx, longint'(p.pos_x));
			vx.vert_y = place(sy[k], szy, longint'(p.pos_y));
			vx.red = col[0][7:0];
			vx.green = col[1][7:0];
			vx.blue = col[2][7:0];
			vx.alpha = col[3][7:0];
			vx.out_u = clip16(uu[k]);
			vx.out_v = clip16(vv[k]);
			vx.last_vertex = (k == 3);
			vertex_q.insert(vertex_q.size(), vx);
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (!idle_en) return 0;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// sender: offers queued particles, predicts each at its transfer
	always @(posedge clk or negedge arst_n) begin
		particle_t cur;
		bit busy;
		int gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			age <= '0; pos_x <= '0; pos_y <= '0; angle <= '0;
			sprite_width <= '0; sprite_height <= '0;
			tex_u <= '0; tex_v <= '0; tex_width <= '0; tex_height <= '0;
			tex_rotated <= 1'b0;
			gap = 0;
		end else begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				predict_quad(cur);
				particles_sent++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap > 0)
					gap--;
				else if (pending_q.size() > 0 &&
						!(pending_q[0].drain_first && vertex_q.size() > 0)) begin
					cur = pending_q.pop_front();
					age <= cur.age; pos_x <= cur.pos_x; pos_y <= cur.pos_y;
					angle <= cur.angle;
					sprite_width <= cur.sprite_width; sprite_height <= cur.sprite_height;
					tex_u <= cur.tex_u; tex_v <= cur.tex_v;
					tex_width <= cur.tex_width; tex_height <= cur.tex_height;
					tex_rotated <= cur.tex_rotated;
					gap = pick_gap();
					busy = 1'b1;
				end
			end
			in_valid <= busy;
		end
	end

	// receiver: checks each vertex transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		vertex_t e;
		int gap, hold;
		if (!arst_n) begin
			ready <= 1'b0;
			gap = 0;
			hold = 0;
		end else begin
			if (valid && ready) begin
				vertices_seen++;
				if (vertex_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected vertex transfer: corner %0d x %0d y %0d",
							corner, vert_x, vert_y);
				end else begin
					e = vertex_q.pop_front();
					if (e.corner !== corner || e.vert_x !== vert_x || e.vert_y !== vert_y ||
							e.red !== red || e.green !== green || e.blue !== blue ||
							e.alpha !== alpha || e.out_u !== out_u || e.out_v !== out_v ||
							e.last_vertex !== last_vertex) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"vertex mismatch exp: c%0d x %0d y %0d ",
								"rgba %h %h %h %h uv %h %h l%0d"},
								e.corner, e.vert_x, e.vert_y, e.red, e.green, e.blue, e.alpha,
								e.out_u, e.out_v, e.last_vertex);
							$display({"               got: c%0d x %0d y %0d ",
								"rgba %h %h %h %h uv %h %h l%0d"},
								corner, vert_x, vert_y, red, green, blue, alpha,
								out_u, out_v, last_vertex);
						end
					end
				end
				// one long stall part way through, so the chain backs up into in_ready
				if (!long_hold_done && vertices_seen == 600) begin
					long_hold_done = 1'b1;
					hold = 400;
				end
			end
			if (hold > 0) begin
				hold--;
				ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				ready <= 1'b0;
			end else begin
				gap = pick_gap();
				ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		int quiet;
		if ((in_valid && in_ready) || (valid && ready)) quiet = 0;
		else quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			sqvg_pkg::REG_START_COLOR: sh_start_color = d;
			sqvg_pkg::REG_END_COLOR:   sh_end_color = d;
			sqvg_pkg::REG_START_SCALE: sh_start_scale = d;
			sqvg_pkg::REG_END_SCALE:   sh_end_scale = d;
			sqvg_pkg::REG_LIFE_RECIP:  sh_life_recip = d[16:0];
			sqvg_pkg::REG_PREMULT:     sh_premult = d[0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until the block is drained
	task automatic wait_idle();
		while (pending_q.size() > 0 || in_valid || vertex_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [15:0] pick16();
		int r;
		r = $urandom_range(15);
		if (r == 0) return 16'h0000;
		if (r == 1) return 16'hFFFF;
		return 16'($urandom());
	endfunction

	function automatic logic [23:0] pick_pos();
		int r;
		r = $urandom_range(15);
		if (r == 0) return 24'h7FFFFF;
		if (r == 1) return 24'h800000;
		if (r < 8) return 24'($urandom_range(65535) - 32768);
		return 24'($urandom());
	endfunction

	function automatic particle_t rand_particle(input int age_max);
		particle_t p;
		p.age = ($urandom_range(9) == 0) ? pick16() : 16'($urandom_range(age_max));
		p.pos_x = pick_pos();
		p.pos_y = pick_pos();
		p.angle = pick16();
		p.sprite_width = ($urandom_range(1) == 0) ? 16'($urandom_range(4095)) : pick16();
		p.sprite_height = ($urandom_range(1) == 0) ? 16'($urandom_range(4095)) : pick16();
		p.tex_u = pick16();
		p.tex_v = pick16();
		p.tex_width = ($urandom_range(1) == 0) ? 16'($urandom_range(8191)) : pick16();
		p.tex_height = ($urandom_range(1) == 0) ? 16'($urandom_range(8191)) : pick16();
		p.tex_rotated = 1'($urandom_range(1));
		p.drain_first = 1'b0;
		return p;
	endfunction

	task automatic add_directed(input logic [15:0] ag, input logic [23:0] px, input logic [23:0] py,
			input logic [15:0] an, input logic [15:0] sw, input logic [15:0] shh,
			input logic [15:0] tw, input logic [15:0] th, input logic rot);
		particle_t p;
		p.age = ag; p.pos_x = px; p.pos_y = py; p.angle = an;
		p.sprite_width = sw; p.sprite_height = shh;
		p.tex_u = 16'h8000; p.tex_v = 16'h4000; p.tex_width = tw; p.tex_height = th;
		p.tex_rotated = rot;
		p.drain_first = 1'b0;
		pending_q.insert(pending_q.size(), p);
	endtask

	task automatic add_random(input int n, input int age_max, input int drain_at);
		particle_t p;
		for (int i = 0; i < n; i++) begin
			p = rand_particle(age_max);
			p.drain_first = (i == drain_at);
			pending_q.insert(pending_q.size(), p);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: corners at quadrant edges, extreme positions, uv overflow
		add_directed(16'd0, 24'd0, 24'd0, 16'h0000, 16'd160, 16'd160, 16'h1000, 16'h2000, 1'b0);
		add_directed(16'd0, 24'd0, 24'd0, 16'h4000, 16'd160, 16'd320, 16'h1000, 16'h2000, 1'b1);
		add_directed(16'd1, 24'd256, 24'hFFFF00, 16'h8000, 16'd80, 16'd80, 16'h0, 16'h0, 1'b0);
		add_directed(16'd5, 24'd0, 24'd0, 16'hC000, 16'd80, 16'd80, 16'hFFFF, 16'hFFFF, 1'b1);
		add_directed(16'hFFFF, 24'd0, 24'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 1'b0);
		add_directed(16'd0, 24'h7FFFFF, 24'h7FFFFF, 16'h2000, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF, 1'b0);
		add_directed(16'd0, 24'h800000, 24'h800000, 16'hA000, 16'hFFFF, 16'hFFFF, 16'h9000, 16'h9000, 1'b1);
		add_directed(16'd0, 24'h7FFFFF, 24'h800000, 16'h6000, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 1'b0);
		add_directed(16'd0, 24'd1000, 24'hFFF000, 16'h0001, 16'd16, 16'd16, 16'h4000, 16'h4000, 1'b1);
		add_directed(16'd0, 24'd0, 24'd0, 16'h3FFF, 16'd48, 16'd48, 16'h0100, 16'h0200, 1'b0);
		wait_idle();

		// blended colors and scales, premultiplied alpha, tween growing with age
		idle_en = 1'b1;
		write_reg(sqvg_pkg::REG_START_COLOR, $urandom());
		write_reg(sqvg_pkg::REG_END_COLOR, $urandom());
		write_reg(sqvg_pkg::REG_START_SCALE, $urandom());
		write_reg(sqvg_pkg::REG_END_SCALE, $urandom());
		write_reg(sqvg_pkg::REG_LIFE_RECIP, $urandom_range(600, 1));
		write_reg(sqvg_pkg::REG_PREMULT, 32'd1);
		write_reg(3'd6, $urandom());  // past the register list, ignored
		write_reg(3'd7, $urandom());
		end_writes();
		add_directed(16'd0, 24'd0, 24'd0, 16'h1234, 16'd64, 16'd64, 16'h100, 16'h100, 1'b0);
		add_directed(16'd200, 24'd0, 24'd0, 16'h5678, 16'd64, 16'd64, 16'h100, 16'h100, 1'b1);
		add_directed(16'hFFFF, 24'd0, 24'd0, 16'h9ABC, 16'd64, 16'd64, 16'h100, 16'h100, 1'b0);
		add_random(115, 400, -1);
		wait_idle();

		// extremes: all-ones scales, colors black to white, zero lifetime reciprocal
		idle_en = 1'b1;
		write_reg(sqvg_pkg::REG_START_COLOR, 32'h0000_0000);
		write_reg(sqvg_pkg::REG_END_COLOR, 32'hFFFF_FFFF);
		write_reg(sqvg_pkg::REG_START_SCALE, 32'hFFFF_FFFF);
		write_reg(sqvg_pkg::REG_END_SCALE, 32'hFFFF_FFFF);
		write_reg(sqvg_pkg::REG_LIFE_RECIP, 32'd0);
		write_reg(sqvg_pkg::REG_PREMULT, 32'd1);
		end_writes();
		add_random(115, 65535, -1);
		wait_idle();

		// full reciprocal, zero scale at birth, no idling at all, one drain pause
		idle_en = 1'b0;
		write_reg(sqvg_pkg::REG_START_COLOR, 32'hFFFF_FFFF);
		write_reg(sqvg_pkg::REG_END_COLOR, 32'h0000_0000);
		write_reg(sqvg_pkg::REG_START_SCALE, 32'h0000_0000);
		write_reg(sqvg_pkg::REG_END_SCALE, $urandom());
		write_reg(sqvg_pkg::REG_LIFE_RECIP, 32'd65536);
		write_reg(sqvg_pkg::REG_PREMULT, 32'd0);
		end_writes();
		add_random(115, 3, 60);
		wait_idle();

		// random settings with a mid-range tween
		idle_en = 1'b1;
		write_reg(sqvg_pkg::REG_START_COLOR, $urandom());
		write_reg(sqvg_pkg::REG_END_COLOR, $urandom());
		write_reg(sqvg_pkg::REG_START_SCALE, $urandom());
		write_reg(sqvg_pkg::REG_END_SCALE, $urandom());
		write_reg(sqvg_pkg::REG_LIFE_RECIP, $urandom_range(65536));
		write_reg(sqvg_pkg::REG_PREMULT, $urandom_range(1));
		end_writes();
		add_random(115, 8, 30);
		wait_idle();

		$display("tb_top: %0d particles over five register settings, %0d vertices checked",
			particles_sent, vertices_seen);
		$display("tb_top: random stalls on both sides, one long receiver stall, %0d mismatches",
			mismatches);
		if (mismatches == 0 && vertex_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
